### hdl/ilp_pkg.sv
// shared types and character codes for the integer literal parser
`timescale 1ns / 1ps
`default_nettype none
package ilp_pkg;

  localparam int VALUE_BITS_DEF = 64;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_DIGIT = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RK_DEC = 2'd0,
    RK_BIN = 2'd1,
    RK_OCT = 2'd2,
    RK_HEX = 2'd3
  } radix_t;

  typedef struct packed {
    radix_t radix;
    logic   negative;
  } acc_ctl_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UO    = 8'h4F;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] HEX_TEN  = 8'd10;

endpackage
`default_nettype wire

### hdl/integer_literal_parser_top.sv
// streaming ascii integer literal parser, top level
// a word is accepted into the input register, then steps the parse state once the
//   result register is free; its result (if any) is registered onto the out_ ports
// throughput: one word per cycle unless out_ready holds off a pending result
// reset: synchronous active-low rst_n clears the parse state and both valid flags
`timescale 1ns / 1ps
`default_nettype none
module integer_literal_parser_top #(
  parameter int VALUE_BITS = ilp_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_ch,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic        [1:0]                 out_status,
  output logic signed [VALUE_BITS-1:0]      out_value,
  output logic        [1:0]                 out_radix_kind
);
  import ilp_pkg::*;

  // input register
  logic       ch_vld_r;
  logic [7:0] ch_r;

  // parse state
  phase_t                phase_r, phase_nxt;
  logic                  neg_r, neg_nxt;
  radix_t                radix_r, radix_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  ovf_r, ovf_nxt;

  // result register
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [VALUE_BITS-1:0] out_value_r;
  radix_t                out_radix_r;

  logic                  advance;
  logic                  emit;
  status_t               em_status;
  logic [VALUE_BITS-1:0] em_value;
  radix_t                em_radix;

  logic                  is_sep, is_dec, is_lhex, is_uhex, is_alpha;
  logic [3:0]            digit;
  logic                  dig_take;
  acc_ctl_t              acc_ctl;
  logic [VALUE_BITS-1:0] acc_sum;
  logic                  acc_ovf;

  assign advance  = ch_vld_r & (~out_valid_r | out_ready);
  assign in_ready = ~ch_vld_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_vld_r <= 1'b0;
    end else if (in_ready) begin
      ch_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r <= in_ch;
    end
  end

  // character classes
  assign is_sep = (ch_r == CH_SPACE) || (ch_r == CH_TAB) || (ch_r == CH_CR) ||
                  (ch_r == CH_VT) || (ch_r == CH_FF) || (ch_r == CH_COMMA);
  assign is_dec   = (ch_r >= CH_ZERO) && (ch_r <= CH_NINE);
  assign is_lhex  = (ch_r >= CH_LA) && (ch_r <= CH_LF);
  assign is_uhex  = (ch_r >= CH_UA) && (ch_r <= CH_UF);
  assign is_alpha = ((ch_r >= CH_LA) && (ch_r <= CH_LZ)) ||
                    ((ch_r >= CH_UA) && (ch_r <= CH_UZ));

  always_comb begin
    logic [7:0] d8;
    if (is_lhex) begin
      d8 = ch_r - CH_LA + HEX_TEN;
    end else if (is_uhex) begin
      d8 = ch_r - CH_UA + HEX_TEN;
    end else begin
      d8 = ch_r - CH_ZERO;
    end
    digit = d8[3:0];
  end

  assign acc_ctl.radix    = radix_r;
  assign acc_ctl.negative = neg_r;

  ilp_acc #(
    .VALUE_BITS(VALUE_BITS)
  ) u_acc (
    .acc   (acc_r),
    .ctl   (acc_ctl),
    .digit (digit),
    .sum   (acc_sum),
    .ovf   (acc_ovf)
  );

  // step logic for the registered word
  always_comb begin
    logic fin;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    radix_nxt = radix_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    emit      = 1'b0;
    fin       = 1'b0;
    dig_take  = 1'b0;
    em_status = ST_NOT_FOUND;
    em_value  = '0;
    em_radix  = RK_DEC;

    unique case (phase_r)
      PH_IDLE, PH_SIGN: begin
        if (is_sep) begin
          phase_nxt = phase_r;
        end else if ((ch_r == CH_MINUS) && (phase_r == PH_IDLE)) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_SIGN;
        end else if (ch_r == CH_ZERO) begin
          phase_nxt = PH_ZERO;
        end else if (is_dec) begin
          dig_take  = 1'b1;
          phase_nxt = PH_DIGITS;
        end else begin
          emit = 1'b1;
        end
      end
      PH_ZERO: begin
        if ((ch_r == CH_LB) || (ch_r == CH_UB)) begin
          radix_nxt = RK_BIN;
          phase_nxt = PH_DIGITS;
        end else if ((ch_r == CH_LO) || (ch_r == CH_UO)) begin
          radix_nxt = RK_OCT;
          phase_nxt = PH_DIGITS;
        end else if ((ch_r == CH_LX) || (ch_r == CH_UX)) begin
          radix_nxt = RK_HEX;
          phase_nxt = PH_DIGITS;
        end else if (is_dec) begin
          dig_take  = 1'b1;
          phase_nxt = PH_DIGITS;
        end else begin
          fin = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (radix_r == RK_HEX) begin
          if (is_dec || is_lhex || is_uhex) begin
            dig_take = 1'b1;
          end else if (is_alpha) begin
            emit      = 1'b1;
            em_status = ST_BAD_DIGIT;
            em_radix  = RK_HEX;
          end else begin
            fin = 1'b1;
          end
        end else if (!is_dec) begin
          fin = 1'b1;
        end else if (((radix_r == RK_BIN) && (ch_r > CH_ONE)) ||
                     ((radix_r == RK_OCT) && (ch_r > CH_SEVEN))) begin
          emit      = 1'b1;
          em_status = ST_BAD_DIGIT;
          em_radix  = radix_r;
        end else begin
          dig_take = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // once past the limit the magnitude stays frozen
    if (dig_take && !ovf_r) begin
      if (acc_ovf) begin
        ovf_nxt = 1'b1;
      end else begin
        acc_nxt = acc_sum;
      end
    end

    if (fin) begin
      emit     = 1'b1;
      em_radix = radix_r;
      if (ovf_r) begin
        em_status = ST_OVERFLOW;
      end else begin
        em_status = ST_FOUND;
        em_value  = neg_r ? ('0 - acc_r) : acc_r;
      end
    end

    if (emit) begin
      phase_nxt = PH_IDLE;
      neg_nxt   = 1'b0;
      radix_nxt = RK_DEC;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      neg_r   <= 1'b0;
      radix_r <= RK_DEC;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      radix_r <= radix_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_status_r <= em_status;
      out_value_r  <= em_value;
      out_radix_r  <= em_radix;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value      = signed'(out_value_r);
  assign out_radix_kind = out_radix_r;

endmodule
`default_nettype wire

### hdl/ilp_acc.sv
// digit accumulate unit: scales the magnitude by the radix, adds a digit, checks the limit
`timescale 1ns / 1ps
`default_nettype none
module ilp_acc #(
  parameter int VALUE_BITS = ilp_pkg::VALUE_BITS_DEF
) (
  input  wire logic [VALUE_BITS-1:0] acc,
  input  wire ilp_pkg::acc_ctl_t     ctl,
  input  wire logic [3:0]            digit,
  output logic      [VALUE_BITS-1:0] sum,
  output logic                       ovf
);
  import ilp_pkg::*;

  localparam int WB = VALUE_BITS + 4;

  logic [WB-1:0] wide;
  logic [WB-1:0] scaled;
  logic [WB-1:0] total;
  logic [WB-1:0] limit;

  assign wide = {4'b0, acc};

  always_comb begin
    unique case (ctl.radix)
      RK_DEC:  scaled = (wide << 3) + (wide << 1);
      RK_BIN:  scaled = wide << 1;
      RK_OCT:  scaled = wide << 3;
      RK_HEX:  scaled = wide << 4;
      default: scaled = '0;
    endcase
  end

  assign total = scaled + WB'(digit);
  // largest magnitude, one more when the literal is negative
  assign limit = WB'({1'b0, {(VALUE_BITS-1){1'b1}}}) + WB'(ctl.negative);
  assign ovf   = total > limit;
  assign sum   = total[VALUE_BITS-1:0];

endmodule
`default_nettype wire
